// ===== sv/joystick_to_bend_and_mod_assert.svh =====
// assertion macros shared by the joystick block
`ifndef JOYSTICK_TO_BEND_AND_MOD_ASSERT_SVH
`define JOYSTICK_TO_BEND_AND_MOD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jbm_pkg.sv =====
`default_nettype none

package jbm_pkg;

    // field widths
    localparam int SAMPLE_W    = 10;
    localparam int CENTER_W    = 10;
    localparam int DEAD_ZONE_W = 8;
    localparam int PITCH_W     = 14;
    localparam int MOD_W       = 7;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_DEAD_ZONE = 3'd2,
        CFG_INVERT_X  = 3'd3,
        CFG_INVERT_Y  = 3'd4
    } cfg_index_t;

    // reset values
    localparam logic [CENTER_W-1:0]    CENTER_RESET    = 10'd512;
    localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RESET = 8'd5;
    localparam int                     SAMPLE_RESET    = 512;

    // filter depth
    localparam int HISTORY_DEPTH_DEFAULT = 4;

    // mapping: out = (offset + 512) * (2^K - 1) / 1024, clamped
    localparam int MAP_BIAS  = 512;
    localparam int MAP_SHIFT = 10;

    // pipeline stage enables from the handshake control
    typedef struct packed {
        logic accept;
        logic load_mean;
        logic load_out;
    } stage_ctl_t;

    // button flags travelling with a request
    typedef struct packed {
        logic held;
        logic went_down;
        logic went_up;
    } button_t;

endpackage

`default_nettype wire

// ===== sv/jbm_channels.sv =====
`default_nettype none

// sample request channel
interface jbm_in_if;
    logic                          valid;
    logic                          ready;
    logic [jbm_pkg::SAMPLE_W-1:0]  x_sample;
    logic [jbm_pkg::SAMPLE_W-1:0]  y_sample;
    logic                          button_level;

    modport source (output valid, output x_sample, output y_sample, output button_level,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input button_level,
                    output ready);
endinterface

// result request channel
interface jbm_out_if;
    logic                          valid;
    logic                          ready;
    logic [jbm_pkg::PITCH_W-1:0]   pitch_bend;
    logic [jbm_pkg::MOD_W-1:0]     modulation;
    logic                          button_held;
    logic                          button_went_down;
    logic                          button_went_up;

    modport source (output valid, output pitch_bend, output modulation, output button_held,
                    output button_went_down, output button_went_up, input ready);
    modport sink   (input valid, input pitch_bend, input modulation, input button_held,
                    input button_went_down, input button_went_up, output ready);
endinterface

`default_nettype wire

// ===== sv/joystick_to_bend_and_mod.sv =====
`default_nettype none

// Joystick to pitch bend and modulation. Each sample request carries one X and one Y
// converter reading and the active-low button pin; each request gives exactly one
// result request. Each axis averages the last HISTORY_DEPTH samples (ring reset to
// 512), subtracts its center, applies the dead zone and optional inversion, and maps
// X to a 14-bit pitch bend (8191 at rest) and Y to a 7-bit modulation (63 at rest).
// The button flags are held level plus one-request press and release pulses.
// Throughput is one request per clock unless the output stalls; each request passes
// the three-stage pipeline (running sum, reciprocal multiply for the mean, shaping
// and scaling into the output register) before its result is presented.
// Each stage holds when the stage after it is full and stalled, so while a finished
// result waits the input takes up to two more requests and then closes until the
// result is taken. Configuration writes take effect at once and must only be
// made while the pipeline is empty.

`include "joystick_to_bend_and_mod_assert.svh"

module joystick_to_bend_and_mod #(
    parameter int HISTORY_DEPTH = jbm_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    jbm_in_if.sink                               samples,
    jbm_out_if.source                            results,
    input  wire logic                            cfg_write,
    input  wire logic [jbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);

    logic [jbm_pkg::CENTER_W-1:0]    center_x_reg;
    logic [jbm_pkg::CENTER_W-1:0]    center_y_reg;
    logic [jbm_pkg::DEAD_ZONE_W-1:0] dead_zone_reg;
    logic                            invert_x_reg;
    logic                            invert_y_reg;

    jbm_pkg::stage_ctl_t ctl;
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                was_down_reg;
    jbm_pkg::button_t    btn_next, btn1_reg, btn2_reg, btn3_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= jbm_pkg::CENTER_RESET;
            center_y_reg  <= jbm_pkg::CENTER_RESET;
            dead_zone_reg <= jbm_pkg::DEAD_ZONE_RESET;
            invert_x_reg  <= 1'b0;
            invert_y_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                jbm_pkg::CFG_CENTER_X:  center_x_reg  <= cfg_data[jbm_pkg::CENTER_W-1:0];
                jbm_pkg::CFG_CENTER_Y:  center_y_reg  <= cfg_data[jbm_pkg::CENTER_W-1:0];
                jbm_pkg::CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[jbm_pkg::DEAD_ZONE_W-1:0];
                jbm_pkg::CFG_INVERT_X:  invert_x_reg  <= cfg_data[0];
                jbm_pkg::CFG_INVERT_Y:  invert_y_reg  <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its contents move on
    always_comb
    begin
        ctl.load_out  = !s3_valid_reg || results.ready;
        ctl.load_mean = !s2_valid_reg || ctl.load_out;
        samples.ready = !s1_valid_reg || ctl.load_mean;
        ctl.accept    = samples.valid && samples.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (ctl.load_mean)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ctl.load_mean)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ctl.load_out)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // shared ring slot and button edge detection
    always_comb
    begin
        slot_next          = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        btn_next.held      = !samples.button_level;
        btn_next.went_down = !samples.button_level && !was_down_reg;
        btn_next.went_up   = samples.button_level && was_down_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            was_down_reg <= 1'b0;
        end
        else if (ctl.accept)
        begin
            slot_reg     <= slot_next;
            was_down_reg <= btn_next.held;
        end
    end

    // button flags follow the request through the stages
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            btn1_reg <= btn_next;
        end
        if (ctl.load_mean)
        begin
            btn2_reg <= btn1_reg;
        end
        if (ctl.load_out)
        begin
            btn3_reg <= btn2_reg;
        end
    end

    // X axis to pitch bend
    jbm_axis #(
        .DEPTH (HISTORY_DEPTH),
        .OUT_K (jbm_pkg::PITCH_W)
    ) u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .slot      (slot_reg),
        .sample    (samples.x_sample),
        .center    (center_x_reg),
        .dead_zone (dead_zone_reg),
        .invert    (invert_x_reg),
        .value     (results.pitch_bend)
    );

    // Y axis to modulation
    jbm_axis #(
        .DEPTH (HISTORY_DEPTH),
        .OUT_K (jbm_pkg::MOD_W)
    ) u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .slot      (slot_reg),
        .sample    (samples.y_sample),
        .center    (center_y_reg),
        .dead_zone (dead_zone_reg),
        .invert    (invert_y_reg),
        .value     (results.modulation)
    );

    // result request
    assign results.valid            = s3_valid_reg;
    assign results.button_held      = btn3_reg.held;
    assign results.button_went_down = btn3_reg.went_down;
    assign results.button_went_up   = btn3_reg.went_up;

    // checks
    `JBM_ASSERT_NOW(a_edges_exclusive, clk, rst_n, results.valid,
        !(results.button_went_down && results.button_went_up),
        "press and release pulse on the same result")
    `JBM_ASSERT_NOW(a_down_means_held, clk, rst_n,
        results.valid && results.button_went_down, results.button_held,
        "press pulse without button held")
    `JBM_ASSERT_NEXT(a_slot_wraps, clk, rst_n,
        ctl.accept && (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)), slot_reg == '0,
        "ring slot did not wrap to zero")
    `JBM_ASSERT_NEXT(a_press_tracked, clk, rst_n,
        ctl.accept && !samples.button_level, was_down_reg,
        "button state not recorded on press")

endmodule

`default_nettype wire

// ===== sv/jbm_axis.sv =====
`default_nettype none

module jbm_axis #(
    parameter int   DEPTH  = jbm_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int   OUT_K  = jbm_pkg::PITCH_W,
    localparam int  SLOT_W = $clog2(DEPTH)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire jbm_pkg::stage_ctl_t             ctl,
    input  wire logic [SLOT_W-1:0]               slot,
    input  wire logic [jbm_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic [jbm_pkg::CENTER_W-1:0]    center,
    input  wire logic [jbm_pkg::DEAD_ZONE_W-1:0] dead_zone,
    input  wire logic                            invert,
    output logic [OUT_K-1:0]                     value
);

    localparam int SW          = jbm_pkg::SAMPLE_W;
    localparam int SUM_W       = SW + $clog2(DEPTH);
    localparam int RECIP_SHIFT = SUM_W + $clog2(DEPTH);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint RECIP_FULL = ((64'd1 << RECIP_SHIFT) + DEPTH - 1) / DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [SUM_W-1:0]   SUM_RESET = SUM_W'(jbm_pkg::SAMPLE_RESET * DEPTH);
    localparam int OFF_W       = SW + 1;
    localparam int BIAS_W      = SW + 2;
    localparam int SCALED_W    = SW + 1 + OUT_K;

    logic [SW-1:0]     ring_reg [DEPTH];
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] product;
    logic [SW-1:0]     mean_reg, mean_next;
    logic [OUT_K-1:0]  value_reg, value_next;

    logic signed [OFF_W-1:0] offset;
    logic                    negative;
    logic [SW-1:0]           magnitude;
    logic [SW-1:0]           shrunk;
    logic                    flip;
    logic [BIAS_W-1:0]       biased;
    logic [SCALED_W-1:0]     scaled;
    logic [OUT_K:0]          quot;

    // running ring sum: swap the oldest sample for the new one
    always_comb
    begin
        sum_next = SUM_W'({1'b0, sum_reg} + (SUM_W+1)'(sample)
                          - (SUM_W+1)'(ring_reg[slot]));
    end

    // ring and running sum, updated on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_reg[i] <= SW'(jbm_pkg::SAMPLE_RESET);
            end
            sum_reg <= SUM_RESET;
        end
        else if (ctl.accept)
        begin
            ring_reg[slot] <= sample;
            sum_reg        <= sum_next;
        end
    end

    // mean by reciprocal multiply, exact for every reachable sum
    always_comb
    begin
        product   = PROD_W'(sum_reg) * PROD_W'(RECIP);
        mean_next = product[RECIP_SHIFT +: SW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mean)
        begin
            mean_reg <= mean_next;
        end
    end

    // center offset, dead zone, inversion, then scale and clamp
    always_comb
    begin
        offset    = $signed({1'b0, mean_reg}) - $signed({1'b0, center});
        negative  = offset[OFF_W-1];
        magnitude = negative ? SW'(-offset) : offset[SW-1:0];
        shrunk    = (magnitude < SW'(dead_zone)) ? '0 : magnitude - SW'(dead_zone);
        flip      = negative ^ invert;
        biased    = flip ? BIAS_W'(jbm_pkg::MAP_BIAS) - BIAS_W'(shrunk)
                         : BIAS_W'(jbm_pkg::MAP_BIAS) + BIAS_W'(shrunk);
        // times (2^K - 1) as shift and subtract
        scaled    = {biased[OFF_W-1:0], {OUT_K{1'b0}}} - SCALED_W'(biased[OFF_W-1:0]);
        quot      = scaled[jbm_pkg::MAP_SHIFT +: OUT_K+1];
        if (biased[BIAS_W-1])
        begin
            value_next = '0;
        end
        else if (quot[OUT_K])
        begin
            value_next = '1;
        end
        else
        begin
            value_next = quot[OUT_K-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire
